[sv/sqr_pkg.sv]
// shared types and constants of the square image rotator
package sqr_pkg;

   // payload and register widths
   localparam int PIX_W     = 8;
   localparam int SIDE_W    = 11;
   localparam int MODE_W    = 3;
   localparam int CSR_IDX_W = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 4'd1;

   // register reset values
   localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;
   localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;

   // reorientation modes, other codes pass the frame through
   localparam logic [MODE_W-1:0] MODE_TRANSPOSE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ROT_RIGHT  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_ROT_LEFT   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_COL_MIRROR = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ROW_MIRROR = 3'd4;

   // per-command control flags from front to back
   typedef struct packed {
      logic rd_en;
      logic last;
   } cmd_flags_type;

   localparam int FLAGS_W = $bits(cmd_flags_type);

endpackage

[sv/sqr_fifo.sv]
// small register queue used between the parts of the rotator
module sqr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == LW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign level    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/sqr_front.sv]
// front part: registers, raster counters and address mapping per beat
module sqr_front #(
   parameter int SIDE_MAX = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_valid,
   input  logic [sqr_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [sqr_pkg::SIDE_W-1:0]              csr_wdata,
   output logic                                    csr_ready,
   input  logic                                    take,
   input  logic [sqr_pkg::PIX_W-1:0]               in_pixel,
   output logic                                    cmd_push,
   output sqr_pkg::cmd_flags_type                  cmd_flags,
   output logic [2*$clog2(SIDE_MAX)+1-1:0]         cmd_rd_addr,
   output logic [2*$clog2(SIDE_MAX)+1-1:0]         cmd_wr_addr,
   output logic [sqr_pkg::PIX_W-1:0]               cmd_pixel
);
   import sqr_pkg::*;

   localparam int CW = $clog2(SIDE_MAX);
   localparam int SW = $clog2(SIDE_MAX + 1);

   logic [SIDE_W-1:0] side_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [CW-1:0]     wr_row_ff, wr_row_in, wr_col_ff, wr_col_in;
   logic [CW-1:0]     rd_row_ff, rd_row_in, rd_col_ff, rd_col_in;
   logic              bank_ff, bank_in;
   logic              ready_ff, ready_in;
   logic [SW-1:0]     eff_side;
   logic [CW-1:0]     s_m1;
   logic [CW-1:0]     src_row, src_col;
   logic              wr_wrap, rd_wrap, csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;

   // clamp the side to the supported range
   always_comb begin
      if ({21'd0, side_ff} < 32'd2) begin
         eff_side = SW'(2);
      end else if ({21'd0, side_ff} > 32'(SIDE_MAX)) begin
         eff_side = SW'(SIDE_MAX);
      end else begin
         eff_side = SW'(side_ff);
      end
   end
   assign s_m1 = CW'(eff_side - 1'b1);

   // source position in the stored frame
   always_comb begin
      unique case (mode_ff)
         MODE_TRANSPOSE: begin
            src_row = rd_col_ff;
            src_col = rd_row_ff;
         end
         MODE_ROT_RIGHT: begin
            src_row = s_m1 - rd_col_ff;
            src_col = rd_row_ff;
         end
         MODE_ROT_LEFT: begin
            src_row = rd_col_ff;
            src_col = s_m1 - rd_row_ff;
         end
         MODE_COL_MIRROR: begin
            src_row = rd_row_ff;
            src_col = s_m1 - rd_col_ff;
         end
         MODE_ROW_MIRROR: begin
            src_row = s_m1 - rd_row_ff;
            src_col = rd_col_ff;
         end
         default: begin
            src_row = rd_row_ff;
            src_col = rd_col_ff;
         end
      endcase
   end

   assign wr_wrap = (wr_row_ff == s_m1) && (wr_col_ff == s_m1);
   assign rd_wrap = (rd_row_ff == s_m1) && (rd_col_ff == s_m1);

   // raster counters advance on each accepted beat
   always_comb begin
      wr_row_in = wr_row_ff;
      wr_col_in = wr_col_ff;
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      bank_in   = bank_ff;
      ready_in  = ready_ff;
      if (take) begin
         if (ready_ff) begin
            if (rd_col_ff == s_m1) begin
               rd_col_in = '0;
               rd_row_in = (rd_row_ff == s_m1) ? '0 : rd_row_ff + 1'b1;
            end else begin
               rd_col_in = rd_col_ff + 1'b1;
            end
         end
         if (wr_col_ff == s_m1) begin
            wr_col_in = '0;
            wr_row_in = (wr_row_ff == s_m1) ? '0 : wr_row_ff + 1'b1;
         end else begin
            wr_col_in = wr_col_ff + 1'b1;
         end
         if (wr_wrap) begin
            bank_in   = ~bank_ff;
            ready_in  = 1'b1;
            rd_row_in = '0;
            rd_col_in = '0;
         end
      end
   end

   // registers and state, a side write restarts the stream
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff   <= SIDE_RESET;
         mode_ff   <= MODE_RESET;
         wr_row_ff <= '0;
         wr_col_ff <= '0;
         rd_row_ff <= '0;
         rd_col_ff <= '0;
         bank_ff   <= 1'b0;
         ready_ff  <= 1'b0;
      end else if (csr_we && (csr_index == CSR_SIDE)) begin
         side_ff   <= csr_wdata;
         wr_row_ff <= '0;
         wr_col_ff <= '0;
         rd_row_ff <= '0;
         rd_col_ff <= '0;
         ready_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_MODE)) begin
            mode_ff <= csr_wdata[MODE_W-1:0];
         end
         wr_row_ff <= wr_row_in;
         wr_col_ff <= wr_col_in;
         rd_row_ff <= rd_row_in;
         rd_col_ff <= rd_col_in;
         bank_ff   <= bank_in;
         ready_ff  <= ready_in;
      end
   end

   // command for the back part
   assign cmd_push        = take;
   assign cmd_flags.rd_en = ready_ff;
   assign cmd_flags.last  = rd_wrap;
   assign cmd_rd_addr     = {~bank_ff, src_row, src_col};
   assign cmd_wr_addr     = {bank_ff, wr_row_ff, wr_col_ff};
   assign cmd_pixel       = in_pixel;

endmodule

[sv/sqr_back.sv]
// back part: frame memory, read stage and result queue
module sqr_back #(
   parameter int AW = 21
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_empty,
   output logic                       cmd_pop,
   input  sqr_pkg::cmd_flags_type     cmd_flags,
   input  logic [AW-1:0]              cmd_rd_addr,
   input  logic [AW-1:0]              cmd_wr_addr,
   input  logic [sqr_pkg::PIX_W-1:0]  cmd_pixel,
   input  logic                       rsp_pop,
   output logic                       rsp_empty,
   output logic [sqr_pkg::PIX_W-1:0]  rsp_out_pixel,
   output logic                       rsp_frame_end
);
   import sqr_pkg::*;

   localparam int OUT_DEPTH = 4;
   localparam int OLW       = $clog2(OUT_DEPTH + 1);

   logic [PIX_W-1:0] bank_mem [2**AW];
   logic [PIX_W-1:0] rd_data_ff;
   logic             rd_last_ff;
   logic             inflight_ff;
   logic [OLW-1:0]   out_level;
   logic             out_full;
   logic             room;

   // a read is only issued when the result queue has room for it
   assign room    = (32'(out_level) + 32'(inflight_ff)) < 32'(OUT_DEPTH);
   assign cmd_pop = !cmd_empty && (!cmd_flags.rd_en || room);

   // frame memory: one write and one registered read per beat
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         bank_mem[cmd_wr_addr] <= cmd_pixel;
      end
      if (cmd_pop && cmd_flags.rd_en) begin
         rd_data_ff <= bank_mem[cmd_rd_addr];
         rd_last_ff <= cmd_flags.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 1'b0;
      end else begin
         inflight_ff <= cmd_pop && cmd_flags.rd_en;
      end
   end

   // result queue
   sqr_fifo #(
      .WIDTH(PIX_W + 1),
      .DEPTH(OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (inflight_ff),
      .push_data ({rd_data_ff, rd_last_ff}),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  ({rsp_out_pixel, rsp_frame_end}),
      .empty     (rsp_empty),
      .level     (out_level)
   );

   // out_full never blocks a push: room accounts for the read in flight
   logic unused_full;
   assign unused_full = out_full;

endmodule

[sv/square_image_rotator_unit.sv]
// top level of the square image rotator
//
// Pixels of a square gray frame enter in raster order on the req_ queue
// port (push/full). The first frame after reset or after a side write is
// only stored; from then on every accepted pixel yields one pixel of the
// previous frame, reoriented by mode, on the rsp_ queue port (empty/pop),
// with frame_end set on the last pixel of each frame. Two banks alternate
// as write and read frame and swap at every frame end.
// Throughput is one pixel per clock while the result queue has room: each
// beat costs one write and one read of the frame memory, on separate ports,
// in the same cycle. A result passes the command queue, the registered
// memory read and the result queue. Registers are written on the csr_ port
// (valid/ready, always ready): index 0 side, index 1 mode; other indexes
// are ignored. The user must write them only while the block is idle; the
// block does not enforce it. Reset clears the counters and selects bank 0;
// memory contents are not cleared and no result refers to them before they
// are written. When the receiver stalls, the result queue fills, the back
// part stops, the command queue fills and full rises; no beat is lost.
module square_image_rotator_unit #(
   parameter int SIDE_MAX = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [sqr_pkg::PIX_W-1:0]           req_in_pixel,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [sqr_pkg::PIX_W-1:0]           rsp_out_pixel,
   output logic                                rsp_frame_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sqr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sqr_pkg::SIDE_W-1:0]          csr_wdata
);
   import sqr_pkg::*;

   localparam int CW     = $clog2(SIDE_MAX);
   localparam int AW     = 2 * CW + 1;
   localparam int CMD_W  = FLAGS_W + 2 * AW + PIX_W;
   localparam int CMD_DEPTH = 4;

   logic                 take;
   logic                 cmd_push;
   cmd_flags_type        f_flags, b_flags;
   logic [AW-1:0]        f_rd_addr, f_wr_addr, b_rd_addr, b_wr_addr;
   logic [PIX_W-1:0]     f_pixel, b_pixel;
   logic                 cmd_empty, cmd_pop;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;

   assign take = req_push && !req_full;

   // front: registers, counters, address mapping
   sqr_front #(
      .SIDE_MAX(SIDE_MAX)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .csr_ready   (csr_ready),
      .take        (take),
      .in_pixel    (req_in_pixel),
      .cmd_push    (cmd_push),
      .cmd_flags   (f_flags),
      .cmd_rd_addr (f_rd_addr),
      .cmd_wr_addr (f_wr_addr),
      .cmd_pixel   (f_pixel)
   );

   // command queue between front and back
   sqr_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({f_flags, f_rd_addr, f_wr_addr, f_pixel}),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  ({b_flags, b_rd_addr, b_wr_addr, b_pixel}),
      .empty     (cmd_empty),
      .level     (cmd_level)
   );

   // back: memory and result queue
   sqr_back #(
      .AW(AW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (cmd_empty),
      .cmd_pop       (cmd_pop),
      .cmd_flags     (b_flags),
      .cmd_rd_addr   (b_rd_addr),
      .cmd_wr_addr   (b_wr_addr),
      .cmd_pixel     (b_pixel),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_frame_end (rsp_frame_end)
   );

   // queue depth is not needed here, full gates the input side
   logic unused_level;
   assign unused_level = ^cmd_level;

endmodule

[sim/sqr_reorient_checker.sv]
// checker for the square image rotator: predicts reoriented pixels and compares result beats
module sqr_reorient_checker #(
   parameter int SIDE_MAX = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [sqr_pkg::PIX_W-1:0]      req_in_pixel,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [sqr_pkg::PIX_W-1:0]      rsp_out_pixel,
   input  logic                           rsp_frame_end,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [sqr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sqr_pkg::SIDE_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import sqr_pkg::*;

   localparam int unsigned BANK_WORDS = SIDE_MAX * SIDE_MAX;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_end;
   } rotated_pixel_type;

   // expected result beats, oldest first
   rotated_pixel_type expected_pixels[$];
   rotated_pixel_type head;

   // shadow of the registers and stream state
   logic [SIDE_W-1:0] side_reg;
   logic [MODE_W-1:0] mode_reg;
   int unsigned       wr_row, wr_col, rd_row, rd_col;
   bit                bank_sel;
   bit                frame_stored;
   int                result_beats;

   // both frame banks, sparse
   bit [PIX_W-1:0] frame_store [int unsigned];

   initial begin
      fail_count      = 0;
      pending_results = 0;
      result_beats    = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] wanted);
      $display("%0t ns: result beat %0d: %s got %0h, wanted %0h",
               $time, result_beats, what, got, wanted);
      fail_count++;
   endtask

   // edge length actually in use, clamped to the supported range
   function automatic int unsigned edge_len();
      if (side_reg < 2) return 2;
      if (side_reg > SIDE_MAX) return SIDE_MAX;
      return side_reg;
   endfunction

   // raster position advance, wrapped set at the end of the frame
   task automatic step_raster(inout int unsigned row, inout int unsigned col,
                              input int unsigned s, output bit wrapped);
      wrapped = 1'b0;
      if (col + 1 >= s) begin
         col = 0;
         if (row + 1 >= s) begin
            row     = 0;
            wrapped = 1'b1;
         end else begin
            row++;
         end
      end else begin
         col++;
      end
   endtask

   task automatic restart_stream();
      wr_row       = 0;
      wr_col       = 0;
      rd_row       = 0;
      rd_col       = 0;
      frame_stored = 1'b0;
   endtask

   // one accepted pixel: read the stored frame if any, then store the pixel
   task automatic predict_reoriented_pixel(input logic [PIX_W-1:0] pix);
      int unsigned       s, sr, sc;
      bit                wrapped;
      rotated_pixel_type want;
      s = edge_len();
      if (frame_stored) begin
         case (mode_reg)
            MODE_TRANSPOSE:  begin sr = rd_col;         sc = rd_row;         end
            MODE_ROT_RIGHT:  begin sr = s - 1 - rd_col; sc = rd_row;         end
            MODE_ROT_LEFT:   begin sr = rd_col;         sc = s - 1 - rd_row; end
            MODE_COL_MIRROR: begin sr = rd_row;         sc = s - 1 - rd_col; end
            MODE_ROW_MIRROR: begin sr = s - 1 - rd_row; sc = rd_col;         end
            default:         begin sr = rd_row;         sc = rd_col;         end
         endcase
         want.pixel = frame_store[(bank_sel ? 0 : BANK_WORDS) + sr * SIDE_MAX + sc];
         step_raster(rd_row, rd_col, s, wrapped);
         want.frame_end = wrapped;
         expected_pixels.push_back(want);
      end
      frame_store[(bank_sel ? BANK_WORDS : 0) + wr_row * SIDE_MAX + wr_col] = pix;
      step_raster(wr_row, wr_col, s, wrapped);
      // frame end: swap banks, the new frame becomes readable
      if (wrapped) begin
         bank_sel     = ~bank_sel;
         frame_stored = 1'b1;
         rd_row       = 0;
         rd_col       = 0;
      end
   endtask

   // watch all three channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         side_reg = SIDE_RESET;
         mode_reg = MODE_RESET;
         bank_sel = 1'b0;
         restart_stream();
         expected_pixels.delete();
      end else begin
         // result beat, older than any pixel accepted at this edge
         if (rsp_pop && !rsp_empty) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected beat, out_pixel", 32'(rsp_out_pixel), 32'd0);
            end else begin
               head = expected_pixels.pop_front();
               if (rsp_out_pixel !== head.pixel)
                  report_mismatch("out_pixel", 32'(rsp_out_pixel), 32'(head.pixel));
               if (rsp_frame_end !== head.frame_end)
                  report_mismatch("frame_end", 32'(rsp_frame_end), 32'(head.frame_end));
            end
            result_beats++;
         end
         // register write
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SIDE) begin
               side_reg = csr_wdata;
               restart_stream();
            end else if (csr_index == CSR_MODE) begin
               mode_reg = csr_wdata[MODE_W-1:0];
            end
         end
         // input beat
         if (req_push && !req_full)
            predict_reoriented_pixel(req_in_pixel);
      end
      pending_results = expected_pixels.size();
   end

endmodule

[sim/square_image_rotator_unit_tb.sv]
// testbench top for the square image rotator: stimulus, idling and verdict
module square_image_rotator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sqr_pkg::*;

   localparam int SIDE_MAX    = 1024;
   localparam int ITEM_TARGET = 650;
   localparam int HOLD_CYCLES = 200;
   // longest legal quiet stretch is the receiver hold plus a few gaps
   localparam int IDLE_LIMIT  = 3000;

   // indexes outside the register list, ignored by the block
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 4'hF;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_push      = 1'b0;
   logic                  req_full;
   logic [PIX_W-1:0]      req_in_pixel  = '0;
   logic                  rsp_empty;
   logic                  rsp_pop       = 1'b0;
   logic [PIX_W-1:0]      rsp_out_pixel;
   logic                  rsp_frame_end;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = '0;
   logic [SIDE_W-1:0]     csr_wdata     = '0;

   int fail_count;
   int pending_results;
   int pixels_sent  = 0;
   int quiet_cycles = 0;
   int tx_calm      = 0;
   int rx_calm      = 0;
   bit hold_off_req = 1'b0;
   bit rx_holding   = 1'b0;

   square_image_rotator_unit #(
      .SIDE_MAX(SIDE_MAX)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_pixel  (req_in_pixel),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   sqr_reorient_checker #(
      .SIDE_MAX(SIDE_MAX)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_pixel    (req_in_pixel),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // idle gap per beat, with occasional stretches of back-to-back beats
   task automatic draw_gap(inout int calm_left, output int gap);
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 19) == 0) begin
         calm_left = $urandom_range(10, 40);
         gap       = 0;
      end else begin
         gap = $urandom_range(0, 16);
      end
   endtask

   // one input beat, called and returning at a falling edge
   task automatic push_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      if (rx_holding) gap = 0;
      else draw_gap(tx_calm, gap);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push     <= 1'b1;
      req_in_pixel <= pix;
      do @(posedge clock); while (req_full);
      pixels_sent++;
      @(negedge clock);
   endtask

   task automatic push_random(input int count);
      repeat (count) push_pixel(PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic end_run();
      req_push <= 1'b0;
      @(negedge clock);
   endtask

   // one register write beat
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SIDE_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait for every expected beat, then let the pipeline drain
   task automatic settle();
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // receiver: random pop gaps, one long hold on request
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rx_holding   = 1'b1;
            rsp_pop     <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rx_holding   = 1'b0;
         end else begin
            draw_gap(rx_calm, gap);
            if (gap > 0) begin
               rsp_pop <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // main stimulus
   initial begin
      int side_val, frame_side, mode_val, count;
      bit new_side;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // side below range acts as 2, prime one frame with extreme pixels
      write_reg(CSR_SIDE, 11'd0);
      write_reg(CSR_MODE, SIDE_W'(MODE_TRANSPOSE));
      push_pixel(8'h00);
      push_pixel(8'hFF);
      push_pixel(8'h5A);
      push_pixel(8'hA5);
      end_run();

      // every mode code, changed every half frame, unused codes pass through
      for (int m = 0; m < 8; m++) begin
         settle();
         write_reg(CSR_MODE, (m == 7) ? 11'h7FF : 11'(m));
         push_pixel((m % 2 == 0) ? 8'hFF : 8'h00);
         push_pixel(PIX_W'($urandom_range(0, 255)));
         end_run();
      end

      // writes to indexes outside the list are ignored
      settle();
      write_reg(CSR_UNUSED_LO, 11'h7FF);
      write_reg(CSR_UNUSED_HI, 11'h7FF);

      // largest side and above range, a few pixels only, then restart
      write_reg(CSR_SIDE, 11'd1024);
      write_reg(CSR_SIDE, 11'h7FF);
      push_random(3);
      end_run();
      settle();

      // receiver holds off while the sender keeps pushing, block fills up
      write_reg(CSR_SIDE, 11'd4);
      write_reg(CSR_MODE, SIDE_W'(MODE_ROT_RIGHT));
      hold_off_req = 1'b1;
      push_random(64);
      end_run();
      settle();

      // random phases, mostly whole frames at small sides
      frame_side = 4;
      while (pixels_sent < ITEM_TARGET) begin
         settle();
         new_side = ($urandom_range(0, 3) != 0);
         if (new_side) begin
            case ($urandom_range(0, 19))
               0:                          side_val = $urandom_range(0, 1);
               1,2,3,4,5,6,7,8,9,10,11,12,13: side_val = $urandom_range(2, 6);
               14,15,16,17,18:             side_val = $urandom_range(7, 12);
               default:                    side_val = $urandom_range(13, 16);
            endcase
            write_reg(CSR_SIDE, SIDE_W'(side_val));
            frame_side = (side_val < 2) ? 2 : side_val;
         end
         mode_val = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
         write_reg(CSR_MODE, SIDE_W'(mode_val));
         if (new_side && $urandom_range(0, 5) == 0)
            count = $urandom_range(1, frame_side * frame_side - 1);
         else if (new_side)
            count = $urandom_range(frame_side * frame_side + 1, 3 * frame_side * frame_side);
         else
            count = $urandom_range(1, 2 * frame_side * frame_side);
         // keep the total close to the item target
         if (count > ITEM_TARGET - pixels_sent)
            count = ITEM_TARGET - pixels_sent;
         push_random(count);
         end_run();
      end

      // drain and verdict
      while (pending_results != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
